// ----- sv/multichannel_windowed_weight_average_core_macros.svh -----
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef MULTICHANNEL_WINDOWED_WEIGHT_AVERAGE_CORE_MACROS_SVH
`define MULTICHANNEL_WINDOWED_WEIGHT_AVERAGE_CORE_MACROS_SVH

// A condition that must hold at every sampled edge.
`define MWWA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold at the same edge as its antecedent.
`define MWWA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold at the edge after its antecedent.
`define MWWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mwwa_pkg.sv -----
`timescale 1ns / 1ps

package mwwa_pkg;

    // Sizing of the per-channel windows.
    localparam int CHANNELS     = 16;
    localparam int WINDOW_DEPTH = 16;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int ADDR_W    = CH_W + POS_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);

    // Field widths of the stream payloads.
    localparam int CHAN_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int AVG_W    = 20;
    localparam int FRAC_W   = 4;

    // Sum of a full window, and the dividend with the fraction bits appended.
    localparam int SUM_W = WEIGHT_W + $clog2(WINDOW_DEPTH);
    localparam int DIV_W = SUM_W + FRAC_W;
    localparam int BIT_W = $clog2(DIV_W + 1);

    // Stream bus widths (whole bytes).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Configuration port.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;
    localparam int WL_W        = 5;
    localparam int WASTE_W     = 4;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_WASTE_CHANNEL = 1'b1;

    localparam logic [WL_W-1:0]    WL_RESET    = 5'd10;
    localparam logic [WASTE_W-1:0] WASTE_RESET = 4'd8;

endpackage

// ----- sv/multichannel_windowed_weight_average_core.sv -----
// Per-channel moving average of load-cell weights, one shared add/subtract unit.
// A sample is written to the reading memory, then the channel's N readings
// (N = readings averaged, 1..16) are summed through the adder and divided in a 24-step
// restoring divide on the same adder; a channel index beyond the channel count skips these steps.
// The block takes a new sample only after the last result is loaded into the output register.
// Reset: rst_n (async, low) clears positions, full and presence flags and loads the registers.
`timescale 1ns / 1ps

module multichannel_windowed_weight_average_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Sample requests: [3:0] channel, [19:4] weight_sample, [20] present.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mwwa_pkg::S_TDATA_W-1:0]   s_tdata,
    // Results: [3:0] result_channel, [23:4] average_weight, [24] inserted,
    // [25] presence_changed, [26] window_full.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mwwa_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwwa_pkg::PADDR_W-1:0]     paddr,
    input  logic [mwwa_pkg::PDATA_W-1:0]     pwdata,
    output logic [mwwa_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam int CH_W   = mwwa_pkg::CH_W;
    localparam int POS_W  = mwwa_pkg::POS_W;
    localparam int ADDR_W = mwwa_pkg::ADDR_W;
    localparam int CNT_W  = mwwa_pkg::CNT_W;
    localparam int SUM_W  = mwwa_pkg::SUM_W;
    localparam int DIV_W  = mwwa_pkg::DIV_W;
    localparam int BIT_W  = mwwa_pkg::BIT_W;

    logic [2:0]                       state_reg, state_next;

    // Configuration registers.
    logic [mwwa_pkg::WL_W-1:0]        wl_reg;
    logic [mwwa_pkg::WASTE_W-1:0]     waste_reg;
    logic                             cfg_we;

    // Per-channel window state.
    logic [POS_W-1:0]                 wpos_reg [mwwa_pkg::CHANNELS];
    logic                             full_reg [mwwa_pkg::CHANNELS];
    logic                             pres_reg [mwwa_pkg::CHANNELS];

    // Reading memory.
    logic [mwwa_pkg::WEIGHT_W-1:0]    mem [mwwa_pkg::MEM_DEPTH];
    logic [mwwa_pkg::WEIGHT_W-1:0]    rd_data_reg;
    logic                             mem_we;
    logic                             mem_re;
    logic [ADDR_W-1:0]                wr_addr;
    logic [ADDR_W-1:0]                rd_addr;

    // Sample held during processing.
    logic [mwwa_pkg::CHAN_W-1:0]      ch_reg;
    logic [mwwa_pkg::WEIGHT_W-1:0]    w_reg;
    logic                             pin_reg;
    logic                             ch_ok;
    logic [CH_W-1:0]                  ci;

    // Window update.
    logic [CNT_W-1:0]                 len;
    logic                             changed;
    logic                             base_full;
    logic [CNT_W-1:0]                 base_pos;
    logic [CNT_W-1:0]                 pos;
    logic [CNT_W-1:0]                 pos_inc;
    logic                             hit_end;
    logic                             full_new;
    logic [CNT_W-1:0]                 npos;
    logic                             upd_we;

    // Summing and division.
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic                             rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]                 acc_reg, acc_next;
    logic [DIV_W-1:0]                 dq_reg, dq_next;
    logic [CNT_W-1:0]                 rem_reg, rem_next;
    logic [BIT_W-1:0]                 bit_cnt_reg, bit_cnt_next;
    logic [CNT_W:0]                   shifted;

    // Shared add/subtract unit.
    logic [SUM_W-1:0]                 alu_a;
    logic [SUM_W-1:0]                 alu_b;
    logic                             alu_sub;
    logic [SUM_W:0]                   alu_res;

    // Result flags and output stage.
    logic                             chg_res_reg, chg_res_next;
    logic                             full_res_reg, full_res_next;
    logic                             ins_res_reg, ins_res_next;
    logic                             m_valid_reg, m_valid_next;
    logic [mwwa_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic                             out_load;
    logic                             s_accept;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= mwwa_pkg::WL_RESET;
            waste_reg <= mwwa_pkg::WASTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[mwwa_pkg::REG_SEL_BIT])
                mwwa_pkg::REG_WINDOW_LENGTH: wl_reg    <= pwdata[mwwa_pkg::WL_W-1:0];
                mwwa_pkg::REG_WASTE_CHANNEL: waste_reg <= pwdata[mwwa_pkg::WASTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[mwwa_pkg::REG_SEL_BIT])
            mwwa_pkg::REG_WINDOW_LENGTH: prdata = mwwa_pkg::PDATA_W'(wl_reg);
            mwwa_pkg::REG_WASTE_CHANNEL: prdata = mwwa_pkg::PDATA_W'(waste_reg);
            default:                     prdata = '0;
        endcase
    end

    // Effective window length: zero counts as one, saturated to the depth.
    always_comb
    begin
        priority if (wl_reg == '0)
            len = CNT_W'(1);
        else if (int'(wl_reg) > mwwa_pkg::WINDOW_DEPTH)
            len = CNT_W'(mwwa_pkg::WINDOW_DEPTH);
        else
            len = CNT_W'(wl_reg);
    end

    // Input handshake.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ch_reg  <= s_tdata[3:0];
            w_reg   <= s_tdata[19:4];
            pin_reg <= s_tdata[20];
        end
    end

    assign ch_ok = (int'(ch_reg) < mwwa_pkg::CHANNELS);
    assign ci    = CH_W'(ch_reg);

    // Window update for the held sample: restart on a non-waste presence change, then advance.
    always_comb
    begin
        changed   = (pres_reg[ci] != pin_reg) && (ch_reg != waste_reg);
        base_pos  = changed ? '0 : CNT_W'(wpos_reg[ci]);
        base_full = changed ? 1'b0 : full_reg[ci];
        pos       = (base_pos >= len) ? '0 : base_pos;
        pos_inc   = pos + CNT_W'(1);
        hit_end   = (pos_inc == len);
        full_new  = base_full | hit_end;
        npos      = hit_end ? '0 : pos_inc;
    end

    assign upd_we  = (state_reg == ST_UPDATE) && ch_ok;
    assign mem_we  = upd_we;
    assign wr_addr = {ci, pos[POS_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mwwa_pkg::CHANNELS; i++)
            begin
                wpos_reg[i] <= '0;
                full_reg[i] <= 1'b0;
                pres_reg[i] <= 1'b0;
            end
        end
        else if (upd_we)
        begin
            wpos_reg[ci] <= npos[POS_W-1:0];
            full_reg[ci] <= full_new;
            pres_reg[ci] <= pin_reg;
        end
    end

    // Reading memory: one write port, one registered read port.
    assign mem_re  = (state_reg == ST_SUM) && (idx_reg != count_reg);
    assign rd_addr = {ci, idx_reg[POS_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= w_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Shared adder: accumulates readings, or tries a subtract for the divider.
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_SUM:
            begin
                alu_a = acc_reg;
                alu_b = SUM_W'(rd_data_reg);
            end
            ST_DIV:
            begin
                alu_a   = SUM_W'(shifted);
                alu_b   = SUM_W'(count_reg);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {SUM_W{alu_sub}}} + (SUM_W+1)'(alu_sub);

    // Sequencer.
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_pend_next  = 1'b0;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        bit_cnt_next  = bit_cnt_reg;
        chg_res_next  = chg_res_reg;
        full_res_next = full_res_reg;
        ins_res_next  = ins_res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                idx_next = '0;
                acc_next = '0;
                if (ch_ok)
                begin
                    // A cleared window never has wrapped, so the position counts the writes.
                    count_next    = full_new ? len : npos;
                    chg_res_next  = changed;
                    full_res_next = full_new;
                    ins_res_next  = pin_reg;
                    state_next    = ST_SUM;
                end
                else
                begin
                    dq_next       = '0;
                    chg_res_next  = 1'b0;
                    full_res_next = 1'b0;
                    ins_res_next  = 1'b0;
                    state_next    = ST_DONE;
                end
            end
            ST_SUM:
            begin
                if (mem_re)
                begin
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                // The last reading arrives once every address has been issued.
                if (rd_pend_reg && (idx_reg == count_reg))
                begin
                    dq_next      = {alu_res[SUM_W-1:0], mwwa_pkg::FRAC_W'(0)};
                    rem_next     = '0;
                    bit_cnt_next = BIT_W'(DIV_W);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_next     = alu_res[SUM_W] ? alu_res[CNT_W-1:0] : shifted[CNT_W-1:0];
                dq_next      = {dq_reg[DIV_W-2:0], alu_res[SUM_W]};
                bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        chg_res_reg  <= chg_res_next;
        full_res_reg <= full_res_next;
        ins_res_reg  <= ins_res_next;
    end

    // Output register: holds a result until it is taken.
    always_comb
    begin
        m_valid_next = m_valid_reg & ~m_tready;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {5'b0, full_res_reg, chg_res_reg, ins_res_reg,
                           dq_reg[mwwa_pkg::AVG_W-1:0], ch_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- sv/mwwa_checker.sv -----
`timescale 1ns / 1ps
`include "multichannel_windowed_weight_average_core_macros.svh"

module mwwa_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mwwa_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             pready
);

    localparam int CHANGED_BIT = 25;

    // The register port never inserts wait states.
    `MWWA_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")

    // One sample at a time: the block is busy right after taking a request.
    `MWWA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "back-to-back accept")

    // A restarted window holds one reading, so the average has no fraction.
    `MWWA_ASSERT_SAME(a_restart_no_fraction, m_tvalid && m_tdata[CHANGED_BIT],
        m_tdata[7:4] == 4'b0, "fraction after window restart")

    // A stalled result stays put.
    `MWWA_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind multichannel_windowed_weight_average_core mwwa_checker u_mwwa_checker (.*);

// ----- dv/tb_multichannel_windowed_weight_average_core.sv -----
`timescale 1ns / 1ps

module tb_multichannel_windowed_weight_average_core;

    // One sample request, channel in the lowest bits as on s_tdata.
    typedef struct packed {
        logic                          present;
        logic [mwwa_pkg::WEIGHT_W-1:0] weight;
        logic [mwwa_pkg::CHAN_W-1:0]   channel;
    } sample_t;

    // One averaged result, channel in the lowest bits as on m_tdata.
    typedef struct packed {
        logic                          window_full;
        logic                          presence_changed;
        logic                          inserted;
        logic [mwwa_pkg::AVG_W-1:0]    average_weight;
        logic [mwwa_pkg::CHAN_W-1:0]   channel;
    } average_t;

    localparam logic [mwwa_pkg::PADDR_W-1:0] ADDR_WINDOW_LENGTH =
        {mwwa_pkg::REG_WINDOW_LENGTH, 2'b00};
    localparam logic [mwwa_pkg::PADDR_W-1:0] ADDR_WASTE_CHANNEL =
        {mwwa_pkg::REG_WASTE_CHANNEL, 2'b00};

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // [3:0] channel, [19:4] weight_sample, [20] present.
    logic [mwwa_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [3:0] result_channel, [23:4] average_weight, [24] inserted,
    // [25] presence_changed, [26] window_full.
    logic [mwwa_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [mwwa_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [mwwa_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [mwwa_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Predicted channel state and register copies.
    logic [mwwa_pkg::WEIGHT_W-1:0] reading_mem [mwwa_pkg::CHANNELS][mwwa_pkg::WINDOW_DEPTH];
    bit          reading_written [mwwa_pkg::CHANNELS][mwwa_pkg::WINDOW_DEPTH];
    int unsigned next_slot [mwwa_pkg::CHANNELS];
    bit          slot_full [mwwa_pkg::CHANNELS];
    bit          tank_in [mwwa_pkg::CHANNELS];
    int unsigned cfg_window = mwwa_pkg::WL_RESET;
    int unsigned cfg_waste  = mwwa_pkg::WASTE_RESET;

    sample_t     sample_pending[$];
    average_t    average_expected[$];
    int unsigned samples_sent     = 0;
    int unsigned samples_accepted = 0;
    int unsigned error_count      = 0;
    int unsigned send_gap         = 0;
    int unsigned stall_left       = 0;
    bit          sender_idles     = 1'b1;
    bit          receiver_idles   = 1'b1;

    multichannel_windowed_weight_average_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Window length in use: zero acts as one, large values saturate.
    function automatic int unsigned window_span();
        int unsigned span;
        span = (cfg_window == 0) ? 1 : cfg_window;
        return (span > mwwa_pkg::WINDOW_DEPTH) ? mwwa_pkg::WINDOW_DEPTH : span;
    endfunction

    // True when averaging this sample would touch a slot never written since reset.
    function automatic bit reads_unwritten(sample_t s);
        int unsigned span;
        int unsigned slot;
        int unsigned count;
        bit          full;
        span = window_span();
        slot = next_slot[s.channel];
        full = slot_full[s.channel];
        if (tank_in[s.channel] != s.present && s.channel != cfg_waste)
        begin
            slot = 0;
            full = 1'b0;
        end
        if (slot >= span)
            slot = 0;
        count = (full || slot == span - 1) ? span : slot + 1;
        for (int j = 0; j < count; j++)
        begin
            if (!reading_written[s.channel][j] && j != slot)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Store the sample in its channel window and compute the truncated mean.
    function automatic average_t apply_sample(sample_t s);
        average_t        r;
        int unsigned     span;
        int unsigned     slot;
        int unsigned     count;
        longint unsigned total;
        span = window_span();
        r.channel = s.channel;
        r.presence_changed = (tank_in[s.channel] != s.present) && (s.channel != cfg_waste);
        if (r.presence_changed)
        begin
            next_slot[s.channel] = 0;
            slot_full[s.channel] = 1'b0;
        end
        tank_in[s.channel] = s.present;

        slot = next_slot[s.channel];
        if (slot >= span)
            slot = 0;
        reading_mem[s.channel][slot] = s.weight;
        reading_written[s.channel][slot] = 1'b1;
        if (slot == span - 1)
            slot_full[s.channel] = 1'b1;
        slot = slot + 1;
        if (slot >= span)
            slot = 0;
        next_slot[s.channel] = slot;

        // Before the window fills, the slot index counts the readings written.
        count = slot_full[s.channel] ? span : slot;
        total = 0;
        for (int j = 0; j < count; j++)
            total += reading_mem[s.channel][j];
        r.average_weight = mwwa_pkg::AVG_W'((total << 4) / count);
        r.inserted = s.present;
        r.window_full = slot_full[s.channel];
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned expected_value,
                                          int unsigned actual_value);
        if (expected_value != actual_value)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
            error_count++;
        end
    endfunction

    function automatic sample_t make_sample(int unsigned ch, int unsigned w, bit p);
        sample_t s;
        s.channel = mwwa_pkg::CHAN_W'(ch);
        s.weight  = mwwa_pkg::WEIGHT_W'(w);
        s.present = p;
        return s;
    endfunction

    // Mostly steady presence on a few channels so windows fill and wrap;
    // the rest is noise on any channel with any presence.
    function automatic sample_t random_sample(int unsigned base, int unsigned span);
        sample_t s;
        if ($urandom_range(0, 7) == 0)
        begin
            s.channel = mwwa_pkg::CHAN_W'($urandom_range(0, mwwa_pkg::CHANNELS - 1));
            s.present = 1'($urandom_range(0, 1));
        end
        else
        begin
            s.channel = mwwa_pkg::CHAN_W'((base + $urandom_range(0, span - 1))
                                          % mwwa_pkg::CHANNELS);
            s.present = ($urandom_range(0, 15) == 0) ? !tank_in[s.channel]
                                                     : tank_in[s.channel];
        end
        case ($urandom_range(0, 7))
            0:       s.weight = '0;
            1:       s.weight = '1;
            default: s.weight = mwwa_pkg::WEIGHT_W'($urandom);
        endcase
        return s;
    endfunction

    // Sample request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (sample_pending.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= mwwa_pkg::S_TDATA_W'(sample_pending.pop_front());
                send_gap <= sender_idles ? $urandom_range(0, 14) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Every accepted sample request predicts one result.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            average_expected.push_back(apply_sample(sample_t'(s_tdata[$bits(sample_t)-1:0])));
            samples_accepted++;
        end
    end

    // Result ready: after each result, stall for a drawn number of valid cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            m_tready   <= 1'b0;
            stall_left <= receiver_idles ? $urandom_range(0, 14) : 0;
        end
        else if (stall_left == 0)
            m_tready <= 1'b1;
        else if (m_tvalid)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        average_t got;
        average_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = average_t'(m_tdata[$bits(average_t)-1:0]);
            if (average_expected.size() == 0)
            begin
                $error("result for channel %0d with no sample waiting", got.channel);
                error_count++;
            end
            else
            begin
                want = average_expected.pop_front();
                compare_field("result_channel", want.channel, got.channel);
                compare_field("average_weight", want.average_weight, got.average_weight);
                compare_field("inserted", want.inserted, got.inserted);
                compare_field("presence_changed", want.presence_changed,
                              got.presence_changed);
                compare_field("window_full", want.window_full, got.window_full);
            end
        end
    end

    // Hand one sample to the driver and wait until the block takes it,
    // so the next one is chosen from up-to-date channel state.
    task automatic send_sample(sample_t s);
        if (reads_unwritten(s))
        begin
            // Restart a window instead; a restarted window reads only the new slot.
            if (s.channel == cfg_waste)
                s.channel = s.channel + 1'b1;
            s.present = !tank_in[s.channel];
        end
        sample_pending.push_back(s);
        samples_sent++;
        while (samples_accepted != samples_sent)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        while (samples_accepted != samples_sent || average_expected.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_register(logic [mwwa_pkg::PADDR_W-1:0] addr,
                                  logic [mwwa_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
        begin
            $error("register %0d read back: expected %0d, actual %0d", addr, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(int unsigned window, int unsigned waste);
        wait_idle();
        write_register(ADDR_WINDOW_LENGTH, mwwa_pkg::PDATA_W'(window));
        cfg_window = window;
        write_register(ADDR_WASTE_CHANNEL, mwwa_pkg::PDATA_W'(waste));
        cfg_waste = waste;
        @(negedge clk);
    endtask

    // Stimulus: directed cases, then random phases over several register settings.
    initial
    begin
        int unsigned window_plan [12];
        int unsigned base;
        int unsigned span;
        int unsigned waste;
        window_plan = '{1, 16, 0, 31, 17, 2, 8, 16, 3, 12, 5, 16};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: insertion, full scale, removal, and the waste channel.
        send_sample(make_sample(0, 16'hFFFF, 1'b1));
        send_sample(make_sample(0, 16'h0000, 1'b1));
        send_sample(make_sample(0, 16'hFFFF, 1'b1));
        send_sample(make_sample(0, 16'h1234, 1'b0));
        send_sample(make_sample(15, 16'h0000, 1'b0));
        send_sample(make_sample(15, 16'hFFFF, 1'b1));
        send_sample(make_sample(8, 16'h0005, 1'b1));
        send_sample(make_sample(8, 16'h0007, 1'b0));

        // Zero length behaves as one reading.
        configure(0, 15);
        send_sample(make_sample(15, 16'hAAAA, 1'b0));
        send_sample(make_sample(3, 16'hFFFF, 1'b1));
        send_sample(make_sample(3, 16'hFFFE, 1'b1));

        // Short window that wraps, then shrinks while full.
        configure(2, 0);
        send_sample(make_sample(5, 16'hFFFF, 1'b1));
        send_sample(make_sample(5, 16'hFFFF, 1'b1));
        send_sample(make_sample(5, 16'h0001, 1'b1));
        configure(1, 0);
        send_sample(make_sample(5, 16'h8000, 1'b1));
        send_sample(make_sample(0, 16'h5555, 1'b1));

        // Length above the window depth saturates.
        configure(31, 3);
        send_sample(make_sample(6, 16'h0001, 1'b1));
        send_sample(make_sample(6, 16'h0002, 1'b1));
        send_sample(make_sample(6, 16'h0003, 1'b1));

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 3)
                0:       waste = 0;
                1:       waste = mwwa_pkg::CHANNELS - 1;
                default: waste = $urandom_range(0, mwwa_pkg::CHANNELS - 1);
            endcase
            configure(window_plan[phase], waste);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            base = $urandom_range(0, mwwa_pkg::CHANNELS - 1);
            span = $urandom_range(1, 4);
            repeat (120) send_sample(random_sample(base, span));
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hang guard.
    initial
    begin
        #15000000;
        $display("Verification failed");
        $finish;
    end

endmodule
